FILE: hw/rtl/vdm_pkg.sv
package vdm_pkg;

    // Field and accumulator widths
    localparam int VAL_W    = 16;
    localparam int N_W      = 17;
    localparam int SUM_W    = 32;
    localparam int SQ_W     = 48;
    localparam int DIST_W   = 48;
    localparam int METRIC_W = 2;

    // Defaults for the top-level parameters
    localparam int MAX_LENGTH_DEF    = 65536;
    localparam int FRACTION_BITS_DEF = 16;

    // Job queue between front and back
    localparam int JOB_QUEUE_DEPTH = 2;
    localparam int QC_W            = $clog2(JOB_QUEUE_DEPTH + 1);

    // Metric register codes; the unused code behaves as manhattan
    localparam logic [METRIC_W-1:0] METRIC_EUCLID    = 2'd0;
    localparam logic [METRIC_W-1:0] METRIC_PEARSON   = 2'd1;
    localparam logic [METRIC_W-1:0] METRIC_MANHATTAN = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Sums of one finished vector pair
    typedef struct packed {
        logic [N_W-1:0]   pair_count;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SQ_W-1:0]  sum_xy;
        logic [SQ_W-1:0]  sum_xx;
        logic [SQ_W-1:0]  sum_yy;
        logic [SUM_W-1:0] sum_abs_diff;
    } t_job;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DISPATCH,
        B_EUC,
        B_MUL,
        B_CHECK,
        B_NORM,
        B_SQX,
        B_SQY,
        B_MULD,
        B_DIVPREP,
        B_DIV,
        B_OUT
    } t_back_state;

    // Clamp a wide distance to the output range
    function automatic logic [DIST_W-1:0] sat_dist(input logic [63:0] v);
        logic [DIST_W-1:0] res;
        if (v > 64'(DIST_MAX)) begin
            res = DIST_MAX;
        end else begin
            res = v[DIST_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/vdm_front.sv
module vdm_front import vdm_pkg::*; #(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [VAL_W-1:0] i_x_value,
    input  logic [VAL_W-1:0] i_y_value,
    input  logic             i_last,
    input  logic [QC_W-1:0]  i_q_count,
    output logic             o_push,
    output t_job             o_job
);

    localparam logic [N_W-1:0] LIMIT = N_W'(MAX_LENGTH);

    // Product stage
    logic               r_s1_valid;
    logic               r_s1_last;
    logic [VAL_W-1:0]   r_s1_x;
    logic [VAL_W-1:0]   r_s1_y;
    logic [2*VAL_W-1:0] r_s1_xy;
    logic [2*VAL_W-1:0] r_s1_xx;
    logic [2*VAL_W-1:0] r_s1_yy;
    logic [VAL_W-1:0]   r_s1_ad;

    // Running sums
    t_job r_sums;
    t_job n_sums;
    logic accept;
    logic add_en;

    // Stall when full or a pending last pair takes the last slot
    assign o_stall = (i_q_count == QC_W'(JOB_QUEUE_DEPTH)) ||
                     ((i_q_count == QC_W'(JOB_QUEUE_DEPTH - 1)) && r_s1_valid && r_s1_last);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last <= i_last;
            r_s1_x    <= i_x_value;
            r_s1_y    <= i_y_value;
            r_s1_xy   <= i_x_value * i_y_value;
            r_s1_xx   <= i_x_value * i_x_value;
            r_s1_yy   <= i_y_value * i_y_value;
            r_s1_ad   <= (i_x_value >= i_y_value) ? i_x_value - i_y_value
                                                  : i_y_value - i_x_value;
        end
    end

    // Accumulate unless the vector has run past its maximum length
    assign add_en = r_s1_valid && (r_sums.pair_count < LIMIT);

    always_comb begin
        n_sums = r_sums;
        if (add_en) begin
            n_sums.pair_count   = r_sums.pair_count + N_W'(1);
            n_sums.sum_x        = r_sums.sum_x + SUM_W'(r_s1_x);
            n_sums.sum_y        = r_sums.sum_y + SUM_W'(r_s1_y);
            n_sums.sum_xy       = r_sums.sum_xy + SQ_W'(r_s1_xy);
            n_sums.sum_xx       = r_sums.sum_xx + SQ_W'(r_s1_xx);
            n_sums.sum_yy       = r_sums.sum_yy + SQ_W'(r_s1_yy);
            n_sums.sum_abs_diff = r_sums.sum_abs_diff + SUM_W'(r_s1_ad);
        end
    end

    assign o_push = r_s1_valid && r_s1_last;
    assign o_job  = n_sums;

    // Clear after handing a finished vector pair to the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
        end else if (o_push) begin
            r_sums <= '0;
        end else begin
            r_sums <= n_sums;
        end
    end

endmodule

FILE: hw/rtl/vdm_job_queue.sv
module vdm_job_queue import vdm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_job            i_job,
    input  logic            i_pop,
    output logic            o_job_valid,
    output t_job            o_job,
    output logic [QC_W-1:0] o_count
);

    localparam int PW = $clog2(JOB_QUEUE_DEPTH);

    t_job            r_mem [JOB_QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [QC_W-1:0] r_count;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] res;
        if (p == PW'(JOB_QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PW'(1);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QC_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QC_W'(1);
            end
        end
    end

    assign o_job_valid = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];
    assign o_count     = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && (r_count == QC_W'(JOB_QUEUE_DEPTH))))
        else $error("job queue overflow");

endmodule

FILE: hw/rtl/vdm_sqrt.sv
module vdm_sqrt import vdm_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_ext,
    input  logic [63:0]               i_value,
    output logic                      o_done,
    output logic [32+FRACTION_BITS-1:0] o_root,
    output logic [35+FRACTION_BITS-1:0] o_rem
);

    localparam int RT_W = 32 + FRACTION_BITS;
    localparam int RM_W = RT_W + 3;
    localparam int IT_W = $clog2(RT_W + 1);

    logic            r_busy;
    logic            r_done;
    logic [63:0]     r_v;
    logic [RT_W-1:0] r_root;
    logic [RM_W-1:0] r_rem;
    logic [IT_W-1:0] r_cnt;
    logic [IT_W-1:0] r_iters;

    logic [RM_W-1:0] rem_s;
    logic [RM_W-1:0] trial;
    logic            fits;

    // One root digit per cycle; zero pairs follow once the operand is used up
    assign rem_s = {r_rem[RM_W-3:0], r_v[63:62]};
    assign trial = RM_W'({r_root, 2'b01});
    assign fits  = (rem_s >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == r_iters - IT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == r_iters - IT_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v     <= i_value;
            r_root  <= '0;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_iters <= i_ext ? IT_W'(RT_W) : IT_W'(32);
        end else if (r_busy) begin
            r_v   <= {r_v[61:0], 2'b00};
            r_cnt <= r_cnt + IT_W'(1);
            if (fits) begin
                r_rem  <= rem_s - trial;
                r_root <= {r_root[RT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_s;
                r_root <= {r_root[RT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
    assign o_rem  = r_rem;

endmodule

FILE: hw/rtl/vdm_div.sv
module vdm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [63:0] r_n;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;

    logic [32:0] t;
    logic        ge;

    // Restoring division, one quotient bit per cycle
    assign t  = {r_rem, r_n[63]};
    assign ge = (t >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 6'd63)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            r_n   <= {r_n[62:0], ge};
            if (ge) begin
                r_rem <= 32'(t - {1'b0, r_den});
            end else begin
                r_rem <= t[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_n;

endmodule

FILE: hw/rtl/vdm_back.sv
module vdm_back import vdm_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [METRIC_W-1:0] i_metric,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [DIST_W-1:0]   o_distance,
    output logic                o_undefined
);

    localparam int RT_W = 32 + FRACTION_BITS;
    localparam int RM_W = RT_W + 3;
    localparam logic [63:0] ONE = 64'(1) << FRACTION_BITS;

    // Product sequence for the pearson variances and covariance
    localparam logic [3:0] MS_XX_LO = 4'd0;
    localparam logic [3:0] MS_XX_HI = 4'd1;
    localparam logic [3:0] MS_X_SQ  = 4'd2;
    localparam logic [3:0] MS_YY_LO = 4'd3;
    localparam logic [3:0] MS_YY_HI = 4'd4;
    localparam logic [3:0] MS_Y_SQ  = 4'd5;
    localparam logic [3:0] MS_XY_LO = 4'd6;
    localparam logic [3:0] MS_XY_HI = 4'd7;
    localparam logic [3:0] MS_X_Y   = 4'd8;

    t_back_state r_state;
    t_back_state n_state;

    t_job              r_job;
    logic [3:0]        r_step;
    logic              r_phase;
    logic [63:0]       r_prod;
    logic [63:0]       r_acc;
    logic [63:0]       r_vx;
    logic [63:0]       r_vy;
    logic [63:0]       r_pb;
    logic [63:0]       r_c;
    logic              r_neg;
    logic [5:0]        r_kx;
    logic [5:0]        r_ky;
    logic [31:0]       r_rx;
    logic [DIST_W-1:0] r_dist;
    logic              r_undef;

    logic [31:0]     mul_a;
    logic [31:0]     mul_b;
    logic            sq_start;
    logic            sq_ext;
    logic [63:0]     sq_value;
    logic            sq_done;
    logic [RT_W-1:0] sq_root;
    logic [RM_W-1:0] sq_rem;
    logic            dv_start;
    logic            dv_done;
    logic [63:0]     dv_quot;

    logic [SQ_W-1:0] euc_sum;
    logic            x_norm_done;
    logic            y_norm_done;
    logic [31:0]     d_raw;
    logic [31:0]     d_den;
    logic [6:0]      k_half;
    logic [63:0]     c_scaled;
    logic [63:0]     div_num;
    logic [63:0]     q_clamp;
    logic            is_manhattan;

    assign is_manhattan = (i_metric != METRIC_EUCLID) && (i_metric != METRIC_PEARSON);
    assign euc_sum      = r_job.sum_xx + r_job.sum_yy - {r_job.sum_xy[SQ_W-2:0], 1'b0};
    assign x_norm_done  = (r_vx[63:62] != 2'b00) || (r_kx == 6'd62);
    assign y_norm_done  = (r_vy[63:62] != 2'b00) || (r_ky == 6'd62);

    // Scale the covariance to the normalized root product
    assign d_raw  = r_prod[63:32];
    assign d_den  = (d_raw == '0) ? 32'd1 : d_raw;
    assign k_half = 7'(({1'b0, r_kx} + {1'b0, r_ky}) >> 1);
    always_comb begin
        if (k_half >= 7'd32) begin
            c_scaled = r_c << (k_half - 7'd32);
        end else begin
            c_scaled = r_c >> (7'd32 - k_half);
        end
    end
    assign div_num = (c_scaled << FRACTION_BITS) + 64'(d_den >> 1);
    assign q_clamp = (dv_quot > ONE) ? ONE : dv_quot;

    vdm_sqrt #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_ext  (sq_ext),
        .i_value(sq_value),
        .o_done (sq_done),
        .o_root (sq_root),
        .o_rem  (sq_rem)
    );

    vdm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(dv_start),
        .i_num  (div_num),
        .i_den  (d_den),
        .o_done (dv_done),
        .o_quot (dv_quot)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:     if (i_job_valid) n_state = B_DISPATCH;
            B_DISPATCH: begin
                if (i_metric == METRIC_EUCLID) begin
                    n_state = B_EUC;
                end else if (i_metric == METRIC_PEARSON) begin
                    n_state = B_MUL;
                end else begin
                    n_state = B_OUT;
                end
            end
            B_EUC:      if (sq_done) n_state = B_OUT;
            B_MUL:      if (r_phase && (r_step == MS_X_Y)) n_state = B_CHECK;
            B_CHECK: begin
                if ((r_vx == '0) || (r_vy == '0)) begin
                    n_state = B_OUT;
                end else begin
                    n_state = B_NORM;
                end
            end
            B_NORM:     if (x_norm_done && y_norm_done) n_state = B_SQX;
            B_SQX:      if (sq_done) n_state = B_SQY;
            B_SQY:      if (sq_done) n_state = B_MULD;
            B_MULD:     n_state = B_DIVPREP;
            B_DIVPREP:  n_state = B_DIV;
            B_DIV:      if (dv_done) n_state = B_OUT;
            B_OUT:      if (!i_stall) n_state = B_IDLE;
            default:    n_state = B_IDLE;
        endcase
    end

    // Control outputs and shared-unit operands
    always_comb begin
        o_pop    = 1'b0;
        o_valid  = 1'b0;
        sq_start = 1'b0;
        sq_ext   = 1'b0;
        sq_value = r_vx;
        dv_start = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            B_IDLE:     o_pop = i_job_valid;
            B_DISPATCH: begin
                sq_start = (i_metric == METRIC_EUCLID);
                sq_ext   = 1'b1;
                sq_value = 64'(euc_sum);
            end
            B_MUL: begin
                unique case (r_step)
                    MS_XX_LO: begin
                        mul_a = 32'(r_job.pair_count);
                        mul_b = r_job.sum_xx[31:0];
                    end
                    MS_XX_HI: begin
                        mul_a = 32'(r_job.pair_count);
                        mul_b = 32'(r_job.sum_xx[SQ_W-1:32]);
                    end
                    MS_X_SQ: begin
                        mul_a = r_job.sum_x;
                        mul_b = r_job.sum_x;
                    end
                    MS_YY_LO: begin
                        mul_a = 32'(r_job.pair_count);
                        mul_b = r_job.sum_yy[31:0];
                    end
                    MS_YY_HI: begin
                        mul_a = 32'(r_job.pair_count);
                        mul_b = 32'(r_job.sum_yy[SQ_W-1:32]);
                    end
                    MS_Y_SQ: begin
                        mul_a = r_job.sum_y;
                        mul_b = r_job.sum_y;
                    end
                    MS_XY_LO: begin
                        mul_a = 32'(r_job.pair_count);
                        mul_b = r_job.sum_xy[31:0];
                    end
                    MS_XY_HI: begin
                        mul_a = 32'(r_job.pair_count);
                        mul_b = 32'(r_job.sum_xy[SQ_W-1:32]);
                    end
                    MS_X_Y: begin
                        mul_a = r_job.sum_x;
                        mul_b = r_job.sum_y;
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            B_NORM: begin
                sq_start = x_norm_done && y_norm_done;
                sq_value = r_vx;
            end
            B_SQX: begin
                sq_start = sq_done;
                sq_value = r_vy;
            end
            B_MULD: begin
                mul_a = r_rx;
                mul_b = sq_root[31:0];
            end
            B_DIVPREP:  dv_start = 1'b1;
            B_OUT:      o_valid = 1'b1;
            default:    o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shared multiplier, registered
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    r_job <= i_job;
                end
            end
            B_DISPATCH: begin
                r_undef <= 1'b0;
                r_step  <= MS_XX_LO;
                r_phase <= 1'b0;
                if (is_manhattan) begin
                    r_dist <= sat_dist(64'(r_job.sum_abs_diff) << FRACTION_BITS);
                end
            end
            B_EUC: begin
                if (sq_done) begin
                    r_dist <= sat_dist(64'(sq_root) + 64'(sq_rem > RM_W'(sq_root)));
                end
            end
            B_MUL: begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_step <= r_step + 4'd1;
                    unique case (r_step)
                        MS_XX_LO, MS_YY_LO, MS_XY_LO: r_acc <= r_prod;
                        MS_XX_HI, MS_YY_HI, MS_XY_HI: r_acc <= r_acc + {r_prod[31:0], 32'b0};
                        MS_X_SQ:  r_vx <= r_acc - r_prod;
                        MS_Y_SQ:  r_vy <= r_acc - r_prod;
                        MS_X_Y:   r_pb <= r_prod;
                        default:  r_pb <= r_pb;
                    endcase
                end
            end
            B_CHECK: begin
                r_neg <= (r_acc < r_pb);
                r_c   <= (r_acc < r_pb) ? r_pb - r_acc : r_acc - r_pb;
                r_kx  <= '0;
                r_ky  <= '0;
                if ((r_vx == '0) || (r_vy == '0)) begin
                    r_undef <= 1'b1;
                    r_dist  <= '0;
                end
            end
            B_NORM: begin
                if (!x_norm_done) begin
                    r_vx <= {r_vx[61:0], 2'b00};
                    r_kx <= r_kx + 6'd2;
                end
                if (!y_norm_done) begin
                    r_vy <= {r_vy[61:0], 2'b00};
                    r_ky <= r_ky + 6'd2;
                end
            end
            B_SQX: begin
                if (sq_done) begin
                    r_rx <= sq_root[31:0];
                end
            end
            B_DIV: begin
                if (dv_done) begin
                    r_dist <= sat_dist(r_neg ? ONE + q_clamp : ONE - q_clamp);
                end
            end
            default: r_rx <= r_rx;
        endcase
    end

    assign o_distance  = r_dist;
    assign o_undefined = r_undef;

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_undefined |-> (o_distance == '0))
        else $error("undefined result with nonzero distance");

    a_undef_pearson: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_undefined |-> (i_metric == METRIC_PEARSON))
        else $error("undefined flag outside pearson");

    a_pearson_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (i_metric == METRIC_PEARSON) && !o_undefined
        |-> (64'(o_distance) <= (ONE << 1)))
        else $error("pearson distance above two");

endmodule

FILE: hw/rtl/vector_distance_metrics.sv
// Streaming distance between two unsigned 16-bit vectors.
// Input channel: i_valid / o_stall carries one element pair (i_x_value,
// i_y_value) per transaction, i_last marks the final pair of a vector.
// Pairs go in one per cycle unless stalled; the front end keeps running sums.
// On a last pair the sums move through a two-entry job queue to the back
// end, which computes one distance (unsigned, FRACTION_BITS fraction bits)
// and presents it on o_valid / i_stall with o_undefined.
// Back end per vector: manhattan scales the sum, euclidean takes one root
// (one root digit per cycle), pearson runs nine products on the shared
// 32x32 multiplier, normalizes both variances, takes two roots and ends
// in a restoring divider. The input stalls when two finished vectors wait in
// the job queue, or when one waits and a last pair sits in the product stage.
// Configuration: i_cfg_valid / o_cfg_ready writes the metric register
// (0 euclidean, 1 pearson, 2 manhattan); change it only while idle.
// Reset (synchronous, i_rst_n low) clears sums, queue and the back end and
// sets the metric to pearson. While i_stall is high the result holds.
module vector_distance_metrics import vdm_pkg::*; #(
    parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [METRIC_W-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [VAL_W-1:0]    i_x_value,
    input  logic [VAL_W-1:0]    i_y_value,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [DIST_W-1:0]   o_distance,
    output logic                o_undefined
);

    logic [METRIC_W-1:0] r_metric;
    logic                push;
    logic                pop;
    logic                job_valid;
    t_job                front_job;
    t_job                queue_job;
    logic [QC_W-1:0]     q_count;

    // Metric register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= METRIC_PEARSON;
        end else if (i_cfg_valid) begin
            r_metric <= i_cfg_data;
        end
    end

    vdm_front #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_x_value(i_x_value),
        .i_y_value(i_y_value),
        .i_last   (i_last),
        .i_q_count(q_count),
        .o_push   (push),
        .o_job    (front_job)
    );

    vdm_job_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (front_job),
        .i_pop      (pop),
        .o_job_valid(job_valid),
        .o_job      (queue_job),
        .o_count    (q_count)
    );

    vdm_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_metric   (r_metric),
        .i_job_valid(job_valid),
        .i_job      (queue_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_distance (o_distance),
        .o_undefined(o_undefined)
    );

endmodule
